/* hdl/adcdf_pkg.sv */
// ----------------------------------------------------------------------------
// adcdf_pkg
// Shared types and constants of the ADC data frame deframer.
// ----------------------------------------------------------------------------
package adcdf_pkg;

	localparam int CHANNELS    = 8;
	localparam int WORD_BYTES  = 3;
	localparam int FRAME_WORDS = CHANNELS + 2;

	localparam int BYTE_W   = 8;
	localparam int SUB_W    = $clog2(WORD_BYTES);
	localparam int WIDX_W   = $clog2(FRAME_WORDS);
	localparam int CH_W     = 3;
	localparam int VAL_W    = 24;
	localparam int STAT_W   = 16;
	localparam int FNUM_W   = 10;
	localparam int CHUNK_W  = 11;

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(64);
	localparam logic [CHUNK_W-1:0] COUNT_LIMIT = CHUNK_W'(1024);

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam int TDATA_W = 40;

	typedef struct packed {
		logic              kind;
		logic [CH_W-1:0]   channel;
		logic [VAL_W-1:0]  value;
		logic              last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* hdl/adcdf_front.sv */
// ----------------------------------------------------------------------------
// adcdf_front
// Takes received bytes, tracks the place in the frame, assembles words and
// hands completed status and channel words to the queue.
// ----------------------------------------------------------------------------
module adcdf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [adcdf_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        frame_start,
	output logic                        push,
	output adcdf_pkg::item_t            item
);
	import adcdf_pkg::*;

	logic [SUB_W-1:0]  sub_q;
	logic [WIDX_W-1:0] word_q;
	logic [VAL_W-1:0]  acc_q;

	logic [SUB_W-1:0]  cur_sub;
	logic [WIDX_W-1:0] cur_word;
	logic [VAL_W-1:0]  acc_next;
	logic              word_done;
	logic [WIDX_W-1:0] ch_idx;

	always_comb begin
		cur_sub   = frame_start ? '0 : sub_q;
		cur_word  = frame_start ? '0 : word_q;
		acc_next  = frame_start ? {{(VAL_W-BYTE_W){1'b0}}, rx_byte}
		                        : {acc_q[VAL_W-BYTE_W-1:0], rx_byte};
		word_done = (cur_sub == SUB_W'(WORD_BYTES - 1));
		ch_idx    = cur_word - WIDX_W'(1);
	end

	assign push = accept && word_done && (cur_word <= WIDX_W'(CHANNELS));

	always_comb begin
		if (cur_word == '0) begin
			item.kind    = KIND_STATUS;
			item.channel = '0;
			item.value   = {{(VAL_W-STAT_W){1'b0}}, acc_next[VAL_W-1 -: STAT_W]};
		end else begin
			item.kind    = KIND_SAMPLE;
			item.channel = ch_idx[CH_W-1:0];
			item.value   = acc_next;
		end
		item.last = (cur_word == WIDX_W'(CHANNELS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= '0;
			word_q <= '0;
			acc_q  <= '0;
		end else if (accept) begin
			acc_q <= acc_next;
			if (word_done) begin
				sub_q  <= '0;
				word_q <= (cur_word == WIDX_W'(FRAME_WORDS - 1)) ? '0 : cur_word + WIDX_W'(1);
			end else begin
				sub_q  <= cur_sub + SUB_W'(1);
				word_q <= cur_word;
			end
		end
	end

endmodule

/* hdl/adcdf_queue.sv */
// ----------------------------------------------------------------------------
// adcdf_queue
// Short first-in first-out queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module adcdf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  adcdf_pkg::item_t      push_item,
	input  logic                  pop,
	output adcdf_pkg::item_t      pop_item,
	output adcdf_pkg::q_status_t  status
);
	import adcdf_pkg::*;

	item_t             mem [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_item     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* hdl/adcdf_back.sv */
// ----------------------------------------------------------------------------
// adcdf_back
// Counts frames against the chunk size, marks chunk-ready samples and holds
// the output word register.
// ----------------------------------------------------------------------------
module adcdf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [adcdf_pkg::CHUNK_W-1:0] cfg_data,
	input  logic                          q_empty,
	input  adcdf_pkg::item_t              q_item,
	output logic                          pop,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic                          m_kind,
	output logic [adcdf_pkg::CH_W-1:0]    m_channel,
	output logic [adcdf_pkg::VAL_W-1:0]   m_value,
	output logic                          m_chunk_ready,
	output logic [adcdf_pkg::FNUM_W-1:0]  m_frame_number
);
	import adcdf_pkg::*;

	logic [CHUNK_W-1:0] chunk_size_q;
	logic [FNUM_W-1:0]  frame_count_q;
	logic               valid_q;
	logic               kind_q;
	logic [CH_W-1:0]    channel_q;
	logic [VAL_W-1:0]   value_q;
	logic               ready_q;
	logic [FNUM_W-1:0]  fnum_q;

	logic [CHUNK_W-1:0] limit;
	logic [CHUNK_W-1:0] next_count;
	logic               hit;

	always_comb begin
		if (chunk_size_q == '0) begin
			limit = CHUNK_W'(1);
		end else if (chunk_size_q > COUNT_LIMIT) begin
			limit = COUNT_LIMIT;
		end else begin
			limit = chunk_size_q;
		end
		next_count = {1'b0, frame_count_q} + CHUNK_W'(1);
		hit        = q_item.last && (next_count >= limit);
	end

	assign pop = !q_empty && (!valid_q || m_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q  <= CHUNK_RESET;
			frame_count_q <= '0;
			valid_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				chunk_size_q <= cfg_data;
			end
			if (pop) begin
				valid_q <= 1'b1;
				if (q_item.last) begin
					frame_count_q <= hit ? '0 : next_count[FNUM_W-1:0];
				end
			end else if (m_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= q_item.kind;
			channel_q <= q_item.channel;
			value_q   <= q_item.value;
			ready_q   <= hit;
			fnum_q    <= frame_count_q;
		end
	end

	assign m_valid        = valid_q;
	assign m_kind         = kind_q;
	assign m_channel      = channel_q;
	assign m_value        = value_q;
	assign m_chunk_ready  = ready_q;
	assign m_frame_number = fnum_q;

endmodule

/* hdl/adc_data_frame_deframer.sv */
// ----------------------------------------------------------------------------
// adc_data_frame_deframer
// Splits received ADC frame bytes into status and channel sample words.
// Throughput: one byte per cycle; the front takes a byte whenever the queue
// has room, the back drains one word per cycle while the output is taken.
// A word passes through a queue entry and then the output word register.
// Reset: asynchronous, clears frame position, frame count and queue, and
// sets the chunk size to 64.
// ----------------------------------------------------------------------------
module adc_data_frame_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // rx_byte
	input  logic                              s_axis_tuser,  // frame_start
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// channel, value, frame_number, zero pad
	output logic [adcdf_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic                              m_axis_tuser,  // kind
	output logic                              m_axis_tlast,  // chunk_ready
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [adcdf_pkg::CHUNK_W-1:0]     cfg_data       // chunk_size
);
	import adcdf_pkg::*;

	logic                 in_accept;
	logic                 push;
	item_t                push_item;
	logic                 pop;
	item_t                pop_item;
	q_status_t            q_status;
	logic [CH_W-1:0]      channel;
	logic [VAL_W-1:0]     value;
	logic [FNUM_W-1:0]    frame_number;

	assign s_axis_tready = !q_status.full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	adcdf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.rx_byte     (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.push        (push),
		.item        (push_item)
	);

	adcdf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	adcdf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.q_empty        (q_status.empty),
		.q_item         (pop_item),
		.pop            (pop),
		.m_valid        (m_axis_tvalid),
		.m_ready        (m_axis_tready),
		.m_kind         (m_axis_tuser),
		.m_channel      (channel),
		.m_value        (value),
		.m_chunk_ready  (m_axis_tlast),
		.m_frame_number (frame_number)
	);

	assign m_axis_tdata = {{(TDATA_W-CH_W-VAL_W-FNUM_W){1'b0}}, frame_number, value, channel};

endmodule
